// ===== hdl/stp_pkg.sv =====
`default_nettype none

package stp_pkg;

  // Default slope shift of the ramp
  localparam int unsigned RAMP_SHIFT_DEF = 2;

  localparam int unsigned PeriodW = 16;
  localparam int unsigned PosW    = 32;
  localparam int unsigned LenW    = 8;

  // Opcodes of an input item
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOG,
    ST_FIX1,
    ST_FIX2,
    ST_EMIT
  } stp_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // input transfer: latch the item
    logic log_step;  // one pass of both length counters
    logic fix1;      // form the raw deceleration length
    logic fix2;      // split any overlap, form the countdown
    logic emit;      // update move state and load the result register
  } stp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic log_done;
  } stp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/stp_in_if.sv =====
`default_nettype none

interface stp_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] target_position;
  logic        [15:0] entry_period;
  logic        [15:0] shortest_period;
  logic        [15:0] exit_period;
  logic        [15:0] exit_steps;

  modport source (
    output valid, opcode, target_position, entry_period, shortest_period,
           exit_period, exit_steps,
    input  ready
  );

  modport sink (
    input  valid, opcode, target_position, entry_period, shortest_period,
           exit_period, exit_steps,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/stp_out_if.sv =====
`default_nettype none

interface stp_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] pulse_period;
  logic signed [31:0] current_position;
  logic               running;

  modport source (
    output valid, pulse_period, current_position, running,
    input  ready
  );

  modport sink (
    input  valid, pulse_period, current_position, running,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/stp_cfg_if.sv =====
`default_nettype none

interface stp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] base_period;

  modport source (
    output valid, base_period,
    input  ready
  );

  modport sink (
    input  valid, base_period,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/stp_ctrl.sv =====
`default_nettype none

module stp_ctrl
  import stp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_opcode_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire stp_sts_t sts_i,
  output stp_cmd_t      cmd_o
);

  stp_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;
  logic       emit_ok;

  assign in_fire = in_valid_i && (state_q == ST_IDLE);
  assign emit_ok = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_opcode_i == OP_START) ? ST_LOG : ST_EMIT;
        end
      end
      ST_LOG: begin
        if (sts_i.log_done) begin
          state_d = ST_FIX1;
        end
      end
      ST_FIX1: state_d = ST_FIX2;
      ST_FIX2: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_fire;
    cmd_o.log_step = (state_q == ST_LOG);
    cmd_o.fix1     = (state_q == ST_FIX1);
    cmd_o.fix2     = (state_q == ST_FIX2);
    cmd_o.emit     = emit_ok;
  end

  // Hold the result valid until its transfer
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (emit_ok) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/stp_dp.sv =====
`default_nettype none

module stp_dp
  import stp_pkg::*;
#(
  parameter int unsigned RampShift = RAMP_SHIFT_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire stp_cmd_t            cmd_i,
  output stp_sts_t                 sts_o,
  input  wire logic                cfg_we_i,
  input  wire logic [PeriodW-1:0]  cfg_base_i,
  input  wire logic                in_opcode_i,
  input  wire logic [PosW-1:0]     in_target_i,
  input  wire logic [PeriodW-1:0]  in_entry_i,
  input  wire logic [PeriodW-1:0]  in_floor_i,
  input  wire logic [PeriodW-1:0]  in_exit_i,
  input  wire logic [PeriodW-1:0]  in_steps_i,
  output logic [PeriodW-1:0]       out_period_o,
  output logic [PosW-1:0]          out_pos_o,
  output logic                     out_run_o
);

  localparam int unsigned DW = PeriodW + 2;

  // Configuration and move state
  logic [PeriodW-1:0] base_q;
  logic               active_q, active_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PosW-1:0]    target_q;
  logic [PeriodW-1:0] period_q, period_d;
  logic [PosW-1:0]    cd_q, cd_d;
  logic [LenW-1:0]    dl_q, dl_d;
  logic [PeriodW-1:0] floor_q;
  logic [PeriodW-1:0] final_q;
  logic [PeriodW-1:0] offset_q;
  logic               op_q;
  logic [PosW-1:0]    len_q;

  // Length counters
  logic [PeriodW-1:0] xa_q, xb_q;
  logic [LenW-1:0]    na_q, nb_q;
  logic               run_a, run_b;

  // Result register
  logic [PeriodW-1:0] res_period_q;
  logic [PosW-1:0]    res_pos_q;
  logic               res_run_q;
  logic               run_d;

  // Overlap split
  logic [LenW:0]      sum9;
  logic               over;
  logic [LenW-1:0]    xo;
  logic [LenW:0]      half;
  logic [PosW-1:0]    cd_base;

  // Tick arithmetic
  logic [PosW-1:0]    pos_n;
  logic [PosW-1:0]    cd_n;
  logic [PeriodW-1:0] sp_acc, sp_dec;
  logic signed [DW-1:0] d_s;
  logic signed [DW-1:0] g_s;

  assign run_a = ((xa_q >> RampShift) != '0) && (na_q != {LenW{1'b1}});
  assign run_b = ((xb_q >> RampShift) != '0) && (nb_q != {LenW{1'b1}});
  assign sts_o.log_done = !run_a && !run_b;

  assign sum9    = {1'b0, na_q} + {1'b0, dl_q};
  assign over    = {{(PosW-LenW-1){1'b0}}, sum9} > len_q;
  assign xo      = sum9[LenW-1:0] - len_q[LenW-1:0];
  assign half    = ({1'b0, xo} + {{LenW{1'b0}}, 1'b1}) >> 1;
  assign cd_base = {{(PosW-LenW){1'b0}}, dl_q} + PosW'(1) - len_q;

  assign pos_n = pos_q + PosW'(1);
  assign cd_n  = cd_q + PosW'(1);

  // Acceleration: shrink geometrically, clamp at the floor
  always_comb begin
    sp_acc = period_q - (period_q >> RampShift) + offset_q;
    if (sp_acc < floor_q) begin
      sp_acc = floor_q;
    end
  end

  // Deceleration: grow by the arithmetically shifted distance to base
  assign d_s = $signed({2'b00, period_q}) - $signed({2'b00, base_q})
             + $signed(DW'(1 << RampShift));
  assign g_s = d_s >>> RampShift;
  always_comb begin
    sp_dec = period_q + g_s[PeriodW-1:0];
    if (sp_dec > final_q) begin
      sp_dec = final_q;
    end
  end

  // Next move state for a tick
  always_comb begin
    active_d = active_q;
    pos_d    = pos_q;
    period_d = period_q;
    cd_d     = cd_q;
    run_d    = 1'b1;
    if (op_q == OP_TICK) begin
      pos_d = pos_n;
      priority if (pos_n == target_q) begin
        period_d = final_q;
        active_d = 1'b0;
        run_d    = 1'b0;
      end else if (!active_q) begin
        run_d = 1'b0;
      end else begin
        cd_d = cd_n;
        priority if (cd_n[PosW-1]) begin
          period_d = sp_acc;
        end else if (cd_n <= {{(PosW-LenW){1'b0}}, dl_q}) begin
          period_d = sp_dec;
        end else begin
          period_d = final_q;
        end
      end
    end
  end

  // Deceleration length: raw at fix1, overlap split at fix2
  always_comb begin
    dl_d = dl_q;
    if (cmd_i.fix1) begin
      dl_d = nb_q + LenW'(4) - LenW'(RampShift);
    end else if (cmd_i.fix2 && over) begin
      dl_d = dl_q - {1'b0, xo[LenW-1:1]} - LenW'(1);
    end
  end

  // Control state of the move
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= PeriodW'(1500);
      active_q <= 1'b0;
      pos_q    <= '0;
      target_q <= '0;
      period_q <= '0;
      cd_q     <= '0;
      dl_q     <= '0;
      floor_q  <= '0;
      final_q  <= '0;
      offset_q <= '0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_base_i;
      end
      dl_q <= dl_d;
      if (cmd_i.load && (in_opcode_i == OP_START)) begin
        active_q <= 1'b1;
        target_q <= in_target_i;
        period_q <= in_entry_i;
        floor_q  <= in_floor_i;
        final_q  <= in_exit_i;
        offset_q <= base_q >> RampShift;
      end
      if (cmd_i.fix2) begin
        cd_q <= over ? (cd_base - {{(PosW-LenW-1){1'b0}}, half}) : cd_base;
      end
      if (cmd_i.emit) begin
        active_q <= active_d;
        pos_q    <= pos_d;
        period_q <= period_d;
        cd_q     <= cd_d;
      end
    end
  end

  // Item latch, length counters and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_opcode_i;
      len_q <= in_target_i - {{(PosW-PeriodW){1'b0}}, in_steps_i};
      xa_q  <= in_entry_i - in_floor_i;
      xb_q  <= in_exit_i - in_floor_i;
      na_q  <= '0;
      nb_q  <= '0;
    end else if (cmd_i.log_step) begin
      if (run_a) begin
        xa_q <= xa_q - (xa_q >> RampShift);
        na_q <= na_q + LenW'(1);
      end
      if (run_b) begin
        xb_q <= xb_q - (xb_q >> RampShift);
        nb_q <= nb_q + LenW'(1);
      end
    end
    if (cmd_i.emit) begin
      res_period_q <= period_d;
      res_pos_q    <= pos_d;
      res_run_q    <= run_d;
    end
  end

  assign out_period_o = res_period_q;
  assign out_pos_o    = res_pos_q;
  assign out_run_o    = res_run_q;

endmodule

`default_nettype wire

// ===== hdl/stepper_trapezoid_period_profile.sv =====
`default_nettype none

// Trapezoidal stepper ramp: a start item (opcode 0) loads a move and yields
// one result with the entry period, the unchanged position and running = 1;
// each tick item (opcode 1) advances the position by one and yields the
// period for the next pulse, shrinking toward the shortest period while
// accelerating and growing back to the exit period before the destination,
// where running drops to 0. The position is kept across moves. Items are
// handled one at a time. A start passes from its transfer through the length
// count, the two fix-up states and the emit state, which forms its result;
// the length counters make one shift-and-subtract pass per cycle (at most
// 255; about 35 for the largest periods at the default shift). A tick goes
// from its transfer straight to the emit state. The result sits in an output
// register, and the next item is taken in the cycle after that register has
// been loaded; a result that waits for its transfer holds the block. The
// base_period register (reset 1500) is always ready; the user must write it
// only between moves; the block itself does not enforce this.
module stepper_trapezoid_period_profile
  import stp_pkg::*;
#(
  parameter int unsigned RampShift = RAMP_SHIFT_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  stp_in_if.sink    in_i,
  stp_out_if.source out_o,
  stp_cfg_if.sink   cfg_i
);

  stp_cmd_t cmd;
  stp_sts_t sts;
  logic     in_ready;
  logic     out_valid;
  logic [PosW-1:0] out_pos;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.current_position = $signed(out_pos);

  stp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  stp_dp #(
    .RampShift (RampShift)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_i.valid),
    .cfg_base_i   (cfg_i.base_period),
    .in_opcode_i  (in_i.opcode),
    .in_target_i  (in_i.target_position),
    .in_entry_i   (in_i.entry_period),
    .in_floor_i   (in_i.shortest_period),
    .in_exit_i    (in_i.exit_period),
    .in_steps_i   (in_i.exit_steps),
    .out_period_o (out_o.pulse_period),
    .out_pos_o    (out_pos),
    .out_run_o    (out_o.running)
  );

`ifndef ASSERT_OFF
  // Not ready in the cycle after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken again right after a transfer");

  // Never overwrite a result that waits for its transfer
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_o.valid || out_o.ready))
    else $error("result register overwritten");

  // Length counting only while no item is taken
  a_log_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.log_step |-> !in_i.ready)
    else $error("length counting while ready");
`endif

endmodule

`default_nettype wire

// ===== dv/stepper_trapezoid_period_profile_tb.sv =====
`timescale 1ns / 1ps

module stepper_trapezoid_period_profile_tb;
  import stp_pkg::*;

  localparam int Shift   = RAMP_SHIFT_DEF;
  localparam int StepAdd = 1 << RAMP_SHIFT_DEF;
  localparam int NumRows = 26;

  typedef struct packed {
    logic        op;
    logic [31:0] tgt;
    logic [15:0] ein;
    logic [15:0] fl;
    logic [15:0] eout;
    logic [15:0] es;
  } stp_item_t;

  typedef struct packed {
    logic [15:0] period;
    logic [31:0] pos;
    logic        running;
  } step_result_t;

  typedef struct packed {
    stp_item_t    item;
    logic         typed;
    step_result_t want;
  } dir_row_t;

  localparam stp_item_t    TickItem  = '{OP_TICK, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0};
  localparam step_result_t NoWant    = '0;
  localparam dir_row_t     PlainTick = '{TickItem, 1'b0, NoWant};

  // Directed moves; rows with typed results are checked against those values
  localparam dir_row_t DirRows [NumRows] = '{
    // tick straight after reset: idle, position still advances
    '{TickItem, 1'b1, '{16'd0, 32'd1, 1'b0}},
    // short move where both ramps overlap
    '{'{OP_START, 32'd9, 16'd2000, 16'd400, 16'd1800, 16'd2}, 1'b1,
      '{16'd2000, 32'd1, 1'b1}},
    PlainTick, PlainTick, PlainTick, PlainTick, PlainTick, PlainTick, PlainTick,
    '{TickItem, 1'b1, '{16'd1800, 32'd9, 1'b0}},
    // tick after the move ended: period held at the exit period
    '{TickItem, 1'b1, '{16'd1800, 32'd10, 1'b0}},
    // largest periods, zero floor
    '{'{OP_START, 32'd14, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 1'b1,
      '{16'hFFFF, 32'd10, 1'b1}},
    PlainTick, PlainTick, PlainTick,
    '{TickItem, 1'b1, '{16'hFFFF, 32'd14, 1'b0}},
    // destination equal to the current position: the first tick passes it
    '{'{OP_START, 32'd14, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b1,
      '{16'h0000, 32'd14, 1'b1}},
    PlainTick, PlainTick,
    // extreme destinations, alternating bit patterns
    '{'{OP_START, 32'h7FFF_FFFF, 16'h5555, 16'hAAAA, 16'h00FF, 16'h8000}, 1'b1,
      '{16'h5555, 32'd16, 1'b1}},
    PlainTick,
    '{'{OP_START, 32'h8000_0000, 16'hAAAA, 16'h5555, 16'hFF00, 16'h7FFF}, 1'b1,
      '{16'hAAAA, 32'd17, 1'b1}},
    PlainTick,
    // flat profile: all periods equal
    '{'{OP_START, 32'd20, 16'd300, 16'd300, 16'd300, 16'd1}, 1'b1,
      '{16'd300, 32'd18, 1'b1}},
    PlainTick,
    '{TickItem, 1'b1, '{16'd300, 32'd20, 1'b0}}
  };

  logic clk_i;
  logic rst_ni;

  stp_in_if  in_bus ();
  stp_out_if out_bus ();
  stp_cfg_if cfg_bus ();

  stepper_trapezoid_period_profile dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // Predicted move state
  logic [15:0] base_q = 16'd1500;
  logic        mv_active = 1'b0;
  logic [31:0] mv_pos = '0;
  logic [31:0] mv_dest = '0;
  logic [15:0] mv_period = '0;
  logic [31:0] mv_countdown = '0;
  logic [7:0]  mv_decel_len = '0;
  logic [15:0] mv_floor = '0;
  logic [15:0] mv_final = '0;
  logic [15:0] mv_offset = '0;

  step_result_t expected_pulses [$];
  int items_sent   = 0;
  int starts_sent  = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int fails        = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Bounded shift-and-subtract length count
  function automatic logic [7:0] ramp_len(input logic [15:0] v);
    int unsigned x;
    int unsigned n;
    x = v;
    n = 0;
    while (x > ((1 << Shift) - 1) && n < 255) begin
      x -= x >> Shift;
      n++;
    end
    return 8'(n);
  endfunction

  function automatic logic calm_window();
    return items_sent >= 450 && items_sent < 600;
  endfunction

  function automatic stp_item_t random_item(input logic op);
    stp_item_t it;
    it.op   = op;
    it.tgt  = $urandom;
    it.ein  = 16'($urandom);
    it.fl   = 16'($urandom);
    it.eout = 16'($urandom);
    it.es   = 16'($urandom);
    return it;
  endfunction

  // Advance the predicted move by one item and form its result
  task automatic predict_period(input stp_item_t it, output step_result_t res);
    logic [15:0] sp;
    logic [15:0] in_gap;
    logic [15:0] out_gap;
    logic [31:0] span;
    logic [31:0] acc;
    logic [31:0] over;
    int          d;
    int          g;
    logic        run;
    if (it.op == OP_START) begin
      in_gap       = it.ein - it.fl;
      out_gap      = it.eout - it.fl;
      mv_period    = it.ein;
      mv_active    = 1'b1;
      mv_dest      = it.tgt;
      mv_floor     = it.fl;
      mv_final     = it.eout;
      mv_offset    = base_q >> Shift;
      span         = it.tgt - {16'd0, it.es};
      acc          = {24'd0, ramp_len(in_gap)};
      mv_decel_len = ramp_len(out_gap) + 8'd4 - 8'(Shift);
      mv_countdown = 32'd0 - (span - {24'd0, mv_decel_len} - 32'd1);
      // split an overlap of the two ramps
      if (acc + {24'd0, mv_decel_len} > span) begin
        over         = (acc + {24'd0, mv_decel_len} - span) & 32'hFF;
        mv_decel_len = mv_decel_len - 8'(over / 2 + 1);
        mv_countdown = mv_countdown - (over + 1) / 2;
      end
      run = 1'b1;
    end else begin
      sp     = mv_period;
      mv_pos = mv_pos + 32'd1;
      if (mv_pos == mv_dest) begin
        mv_period = mv_final;
        mv_active = 1'b0;
        run       = 1'b0;
      end else if (!mv_active) begin
        run = 1'b0;
      end else begin
        mv_countdown = mv_countdown + 32'd1;
        if (mv_countdown[31]) begin
          // accelerate: shrink geometrically, clamp at the floor
          sp = sp - (sp >> Shift);
          sp = sp + mv_offset;
          if (sp < mv_floor) sp = mv_floor;
        end else if (mv_countdown <= {24'd0, mv_decel_len}) begin
          // decelerate: grow by a floored fraction of the distance to base
          d  = int'(sp) - int'(base_q) + StepAdd;
          g  = d >>> Shift;
          sp = sp + g[15:0];
          if (sp > mv_final) sp = mv_final;
        end else begin
          sp = mv_final;
        end
        mv_period = sp;
        run       = 1'b1;
      end
    end
    res = '{mv_period, mv_pos, run};
  endtask

  // Offer one item, wait for its transfer, then queue its expected result
  task automatic offer_item(input stp_item_t it, input logic typed, input step_result_t want);
    int           gap;
    step_result_t got;
    gap = 0;
    while (!calm_window() && $urandom_range(0, 99) < 6) gap++;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid           <= 1'b1;
    in_bus.opcode          <= it.op;
    in_bus.target_position <= it.tgt;
    in_bus.entry_period    <= it.ein;
    in_bus.shortest_period <= it.fl;
    in_bus.exit_period     <= it.eout;
    in_bus.exit_steps      <= it.es;
    do @(posedge clk_i); while (!in_bus.ready);
    predict_period(it, got);
    expected_pulses.push_back(typed ? want : got);
    items_sent++;
    if (it.op == OP_START) starts_sent++;
  endtask

  // Drain the block, then write base_period
  task automatic write_base(input logic [15:0] value);
    in_bus.valid <= 1'b0;
    while (expected_pulses.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.base_period <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    base_q = value;
    cfg_writes++;
  endtask

  // Mostly complete moves toward nearby destinations, plus noise
  task automatic run_moves(input int budget);
    int        stop_at;
    int        hop;
    int        n_ticks;
    int        pick;
    stp_item_t it;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        hop = ($urandom_range(0, 9) == 0) ? $urandom_range(61, 250) : $urandom_range(1, 60);
        it  = random_item(OP_START);
        case ($urandom_range(0, 2))
          0: begin
            it.fl   = 16'($urandom_range(100, 2000));
            it.ein  = it.fl + 16'($urandom_range(0, 30000));
            it.eout = it.fl + 16'($urandom_range(0, 30000));
          end
          1: begin
            it.fl = 16'($urandom_range(0, 50));
          end
          default: ;
        endcase
        if ($urandom_range(0, 3) != 0) it.es = 16'($urandom_range(0, hop));
        it.tgt = mv_pos + 32'(hop);
        offer_item(it, 1'b0, NoWant);
        n_ticks = hop + $urandom_range(0, 2);
        // cut some moves short by a new start
        if ($urandom_range(0, 99) < 12) n_ticks = $urandom_range(0, hop - 1);
        repeat (n_ticks) offer_item(random_item(OP_TICK), 1'b0, NoWant);
      end else if (pick < 90) begin
        offer_item(random_item(OP_START), 1'b0, NoWant);
        repeat ($urandom_range(0, 5)) offer_item(random_item(OP_TICK), 1'b0, NoWant);
      end else begin
        repeat ($urandom_range(1, 6)) offer_item(random_item(OP_TICK), 1'b0, NoWant);
      end
    end
  endtask

  // Result side: random backpressure and one long hold-off
  initial begin
    logic held;
    held          = 1'b0;
    out_bus.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        out_bus.ready <= calm_window() || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    step_result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_pulses.size() == 0) begin
        $error("result with no expectation: pulse_period %0d position %0d running %0b",
               out_bus.pulse_period, out_bus.current_position, out_bus.running);
        fails++;
      end else begin
        want = expected_pulses.pop_front();
        results_seen++;
        if (out_bus.pulse_period !== want.period) begin
          $error("pulse_period: expected %0d, actual %0d", want.period, out_bus.pulse_period);
          fails++;
        end
        if (out_bus.current_position !== want.pos) begin
          $error("current_position: expected %0d, actual %0d",
                 $signed(want.pos), out_bus.current_position);
          fails++;
        end
        if (out_bus.running !== want.running) begin
          $error("running: expected %0b, actual %0b", want.running, out_bus.running);
          fails++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("stepper_trapezoid_period_profile test failed");
    $finish;
  end

  initial begin
    logic [15:0] base_set [5];
    in_bus.valid           = 1'b0;
    in_bus.opcode          = OP_START;
    in_bus.target_position = '0;
    in_bus.entry_period    = '0;
    in_bus.shortest_period = '0;
    in_bus.exit_period     = '0;
    in_bus.exit_steps      = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.base_period    = '0;
    rst_ni                 = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at the reset value of base_period
    for (int i = 0; i < NumRows; i++) begin
      offer_item(DirRows[i].item, DirRows[i].typed, DirRows[i].want);
    end

    // Random moves under several base_period settings
    base_set = '{16'd0, 16'hFFFF, 16'($urandom), 16'd1500, 16'd3};
    for (int p = 0; p < 5; p++) begin
      write_base(base_set[p]);
      run_moves(130);
    end

    // Drop valid and drain
    in_bus.valid <= 1'b0;
    while (expected_pulses.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d items (%0d starts, %0d ticks), %0d results checked.",
             items_sent, starts_sent, items_sent - starts_sent, results_seen);
    $display("Base period took %0d settings incl. 0 and 65535; one long output stall.",
             cfg_writes + 1);
    if (fails == 0 && expected_pulses.size() == 0) begin
      $display("stepper_trapezoid_period_profile test passed");
    end else begin
      $display("stepper_trapezoid_period_profile test failed");
    end
    $finish;
  end

endmodule
